### rtl/core/tdpc_pkg.sv
// Shared types and constants for the trial-division prime counter.
// No dependencies; imported by every module of the block.
package tdpc_pkg;

	// Field and datapath widths
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 32;
	localparam int TOTAL_BITS  = 32;
	localparam int DIV_BITS    = VALUE_BITS / 2;
	localparam int DSQ_BITS    = VALUE_BITS;
	localparam int RADIX_BITS  = 4;
	localparam int MOD_STEPS   = VALUE_BITS / RADIX_BITS;
	localparam int STEP_BITS   = $clog2(MOD_STEPS);
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [DIV_BITS-1:0]   FIRST_DIV = DIV_BITS'(3);
	localparam logic [DSQ_BITS-1:0]   FIRST_DSQ = DSQ_BITS'(9);

	// One input word
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} item_t;

	// One result word
	typedef struct packed {
		logic                  is_prime;
		logic [TOTAL_BITS-1:0] prime_total;
		logic                  set_done;
	} result_t;

	// Front-end classification of a value
	typedef enum logic [1:0] {
		CLS_NOT_PRIME = 2'd0,
		CLS_PRIME     = 2'd1,
		CLS_TEST      = 2'd2
	} cls_t;

	// Queue entry between front and back
	typedef struct packed {
		logic [VALUE_BITS-1:0] n;
		logic                  last;
		cls_t                  cls;
	} task_t;

	// Remainder unit status
	typedef struct packed {
		logic done;
		logic rem_zero;
	} mod_stat_t;

endpackage

### rtl/core/tdpc_front.sv
// Front end: accepts input words, classifies each value, and queues it.
// Depends on tdpc_pkg.
module tdpc_front
	import tdpc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  head_valid,
	output task_t head,
	input  logic  pop
);

	task_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	task_t                 entry;
	logic                  push;
	logic                  do_pop;

	// Classify: negative, 0, 1 and even values other than 2 need no test
	always_comb begin
		entry.n    = item.value;
		entry.last = item.last;
		if (item.value[VALUE_BITS-1] || (item.value[VALUE_BITS-1:1] == '0)) begin
			entry.cls = CLS_NOT_PRIME;
		end else if (item.value == VALUE_BITS'(2)) begin
			entry.cls = CLS_PRIME;
		end else if (!item.value[0]) begin
			entry.cls = CLS_NOT_PRIME;
		end else begin
			entry.cls = CLS_TEST;
		end
	end

	assign item_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign push       = item_valid && item_ready;
	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/tdpc_mod.sv
// Iterative remainder unit: dividend mod divisor, RADIX_BITS quotient bits per cycle.
// Depends on tdpc_pkg.
module tdpc_mod
	import tdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]   divisor,
	output mod_stat_t             stat
);

	logic [VALUE_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] dvd_nxt;
	logic [DIV_BITS-1:0]   rem_nxt;

	// RADIX_BITS restoring steps; remainder stays below the divisor
	always_comb begin
		logic [DIV_BITS:0] t;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		for (int i = 0; i < RADIX_BITS; i++) begin
			t       = {rem_nxt, dvd_nxt[VALUE_BITS-1]};
			dvd_nxt = {dvd_nxt[VALUE_BITS-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				rem_nxt = DIV_BITS'(t - {1'b0, divisor});
			end else begin
				rem_nxt = t[DIV_BITS-1:0];
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

### rtl/core/tdpc_back.sv
// Back end: trial-division sequencer, running prime count and output register.
// Depends on tdpc_pkg and tdpc_mod.
module tdpc_back
	import tdpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  task_t   head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] n_q;
	logic                  last_q;
	logic                  prime_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [DSQ_BITS-1:0]   dsq_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  out_free;
	logic                  emit;
	logic                  emit_prime;
	logic                  emit_last;
	logic                  mod_start;
	logic [COUNT_BITS-1:0] count_nxt;
	mod_stat_t             mod_stat;

	tdpc_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (mod_stat)
	);

	assign out_free = !out_valid_q || result_ready;

	// Control decode
	always_comb begin
		pop        = 1'b0;
		emit       = 1'b0;
		emit_prime = 1'b0;
		emit_last  = 1'b0;
		mod_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (head.cls == CLS_TEST) begin
						pop = 1'b1;
					end else if (out_free) begin
						pop        = 1'b1;
						emit       = 1'b1;
						emit_prime = (head.cls == CLS_PRIME);
						emit_last  = head.last;
					end
				end
			end
			ST_CHECK: begin
				mod_start = (dsq_q <= n_q);
			end
			ST_DIV: begin
			end
			ST_DONE: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_prime = prime_q;
					emit_last  = last_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Saturating count including this word
	assign count_nxt = (emit_prime && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid && (head.cls == CLS_TEST)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= mod_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (mod_stat.done) begin
						state_q <= mod_stat.rem_zero ? ST_DONE : ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Trial divisor, its square and the verdict
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			n_q    <= head.n;
			last_q <= head.last;
			d_q    <= FIRST_DIV;
			dsq_q  <= FIRST_DSQ;
		end
		if ((state_q == ST_CHECK) && !mod_start) begin
			prime_q <= 1'b1;
		end
		if ((state_q == ST_DIV) && mod_stat.done) begin
			if (mod_stat.rem_zero) begin
				prime_q <= 1'b0;
			end else begin
				// (d + 2)^2 = d^2 + 4d + 4
				d_q   <= d_q + DIV_BITS'(2);
				dsq_q <= dsq_q + DSQ_BITS'({d_q, 2'b00}) + DSQ_BITS'(4);
			end
		end
	end

	// Running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (emit) begin
			count_q <= emit_last ? '0 : count_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.is_prime    <= emit_prime;
			out_q.prime_total <= TOTAL_BITS'(count_nxt);
			out_q.set_done    <= emit_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/core/trial_division_prime_counter.sv
// Top level of the trial-division prime counter.
// Depends on tdpc_pkg, tdpc_front and tdpc_back.
//
//   channel | signals                           | word
//   input   | item_valid, item_ready, item      | item_t   {value, last}
//   output  | result_valid, result_ready, result| result_t {is_prime, prime_total, set_done}
//
// Negative, 0, 1, 2 and even values go from the queue head into the output register once it is free.
// Other odd values are tried against odd divisors (3, 5, ... while d*d <= value) until one divides,
// each trial run by the remainder unit retiring 4 quotient bits a cycle.
// Words are tested one at a time; a 2-deep queue keeps the input taking words meanwhile.
// arst_n clears the queue, the sequencer, the count and the output valid.
// A stalled output holds the back end; the queue keeps accepting until full.
module trial_division_prime_counter
	import tdpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic  head_valid;
	task_t head;
	logic  pop;

	tdpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	tdpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### tb/sv/tb_trial_division_prime_counter.sv
// Self-checking testbench for trial_division_prime_counter: directed table, then random words.
// Depends on tdpc_pkg and the trial_division_prime_counter RTL; uses no files or arguments.
module tb_trial_division_prime_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import tdpc_pkg::*;

	localparam int STALL_LIMIT   = 1_000_000;
	localparam int RANDOM_WORDS  = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int REPORT_MAX    = 10;
	localparam int DIRECTED_ROWS = 20;

	// One directed row; the result is typed in only where 'known' is set
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
		logic                         known;
		logic                         is_prime;
		logic [TOTAL_BITS-1:0]        total;
	} probe_row_t;

	localparam probe_row_t PROBE_ROWS [DIRECTED_ROWS] = '{
		'{32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'd0},	// most negative
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd0},	// minus one
		'{32'd0,         1'b0, 1'b1, 1'b0, 32'd0},
		'{32'd1,         1'b0, 1'b1, 1'b0, 32'd0},
		'{32'd2,         1'b0, 1'b1, 1'b1, 32'd1},	// only even prime
		'{32'd3,         1'b0, 1'b1, 1'b1, 32'd2},
		'{32'd4,         1'b0, 1'b1, 1'b0, 32'd2},
		'{32'd9,         1'b0, 1'b1, 1'b0, 32'd2},	// divisor squared equals value
		'{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'd3},	// largest value, prime, slow
		'{32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0, 32'd3},
		'{32'd5,         1'b1, 1'b1, 1'b1, 32'd4},	// closes the set
		'{32'd7,         1'b1, 1'b1, 1'b1, 32'd1},	// count restarted
		'{32'd4,         1'b1, 1'b1, 1'b0, 32'd0},
		'{32'd49,        1'b0, 1'b0, 1'b0, 32'd0},
		'{32'd25,        1'b0, 1'b0, 1'b0, 32'd0},
		'{32'h7FFF_FFFD, 1'b0, 1'b0, 1'b0, 32'd0},
		'{32'd65521,     1'b0, 1'b0, 1'b0, 32'd0},
		'{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'd0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'd0},
		'{32'd65537,     1'b1, 1'b0, 1'b0, 32'd0}
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// predictor state and scoreboard
	logic [COUNT_BITS-1:0] prime_count;
	result_t               pending_results[$];
	result_t               head;
	int                    mismatches;
	int                    results_checked;
	int                    words_sent;
	int                    primes_seen;
	int                    sets_closed;
	int                    quiet_cycles;
	bit                    steady;
	bit                    hold_go;

	trial_division_prime_counter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Trial division with the exact bound d <= n / d
	function automatic bit value_is_prime(logic signed [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] raw;
		longint unsigned       n;
		longint unsigned       d;
		raw = v;
		if (raw[VALUE_BITS-1])
			return 1'b0;
		n = raw;
		if (n <= 1)
			return 1'b0;
		if (n == 2)
			return 1'b1;
		if (!raw[0])
			return 1'b0;
		for (d = 3; d <= n / d; d += 2)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Advances the running count and returns the result this word should produce
	function automatic result_t predict_prime_result(item_t w);
		result_t r;
		bit      p;
		p = value_is_prime(w.value);
		if (p && prime_count != COUNT_MAX)
			prime_count = prime_count + 1'b1;
		r.is_prime    = p;
		r.prime_total = TOTAL_BITS'(prime_count);
		r.set_done    = w.last;
		if (w.last)
			prime_count = '0;
		return r;
	endfunction

	// Random word: mostly small values, plus negatives, large evens and large multiples of 3
	function automatic item_t random_word();
		item_t w;
		int    kind;
		kind = $urandom_range(0, 99);
		if (kind < 45)
			w.value = $urandom_range(0, 20000);
		else if (kind < 60)
			w.value = $urandom() | 32'h8000_0000;
		else if (kind < 75)
			w.value = $urandom() & 32'h7FFF_FFFE;
		else if (kind < 85)
			w.value = $urandom_range(0, 3);
		else
			w.value = 32'd3 * $urandom_range(1, 715827882);
		w.last = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	// Offer one word, hold it until accepted, then record what it should yield
	task automatic send_word(input item_t w, input bit known, input result_t typed);
		result_t want;
		while (!steady && $urandom_range(0, 99) < 31) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item       = w;
		do @(posedge clk); while (!item_ready);
		want = predict_prime_result(w);
		if (known)
			want = typed;
		pending_results.push_back(want);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Receiver: random back-pressure, a steady stretch, and one long hold-off
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go      = 1'b0;
				result_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ready = steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
		end
	end

	// Compare each accepted result with the oldest pending expectation
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, total", 32'd0, result.prime_total);
			end else begin
				head = pending_results.pop_front();
				if (result.is_prime !== head.is_prime)
					report_mismatch("is_prime", 32'(head.is_prime), 32'(result.is_prime));
				if (result.prime_total !== head.prime_total)
					report_mismatch("prime_total", head.prime_total, result.prime_total);
				if (result.set_done !== head.set_done)
					report_mismatch("set_done", 32'(head.set_done), 32'(result.set_done));
				if (head.is_prime)
					primes_seen++;
				if (head.set_done)
					sets_closed++;
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d idle cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Main sequence
	initial begin
		result_t typed;
		item_t   w;
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item            = '0;
		prime_count     = '0;
		mismatches      = 0;
		results_checked = 0;
		words_sent      = 0;
		primes_seen     = 0;
		sets_closed     = 0;
		quiet_cycles    = 0;
		steady          = 1'b0;
		hold_go         = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			w.value            = PROBE_ROWS[i].value;
			w.last             = PROBE_ROWS[i].last;
			typed.is_prime     = PROBE_ROWS[i].is_prime;
			typed.prime_total  = PROBE_ROWS[i].total;
			typed.set_done     = PROBE_ROWS[i].last;
			send_word(w, PROBE_ROWS[i].known, typed);
		end

		// sender pauses until the block has drained
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);

		// random words; a no-idle stretch, then a long receiver hold-off
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady = (i >= 30 && i < 60);
			if (i == 65)
				hold_go = 1'b1;
			send_word(random_word(), 1'b0, typed);
		end
		item_valid = 1'b0;
		steady     = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d words, checked %0d results: %0d primes, %0d closed sets.",
			words_sent, results_checked, primes_seen, sets_closed);
		$display("Covered sign and range extremes, set restarts, stalls on both sides.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
